@@ design/scok_pkg.sv @@
// ----------------------------------------------------------------------------
// scok_pkg: shared types and constants of the swap-cipher keystream block
// Item types between front and back, schedule sizes and the bit exchange.
// ----------------------------------------------------------------------------
package scok_pkg;

    localparam int ROUNDS       = 4;
    localparam int SCHED_PASSES = 768;
    localparam int PERM_DEPTH   = 128;
    localparam int PERM_AW      = 7;
    localparam int PERM_W       = 5;
    localparam int DATA_W       = 136;

    localparam logic ACT_SCHED = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    // one queued word, count already clamped to sixteen
    typedef struct packed {
        logic        action;
        logic [63:0] word_high;
        logic [63:0] word_low;
        logic [4:0]  byte_count;
    } item_t;

    // queue head as seen by the back part
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_t;

    // exchange bits p and q of w
    function automatic logic [31:0] exch_bits(input logic [31:0] w,
                                              input logic [4:0] p,
                                              input logic [4:0] q);
        logic        diff;
        logic [31:0] m;
        diff = w[p] ^ w[q];
        m = (32'(diff) << p) | (32'(diff) << q);
        return w ^ m;
    endfunction

endpackage

@@ design/scok_ram.sv @@
// ----------------------------------------------------------------------------
// scok_ram: generic single-write, dual-read memory
// Registered read data on both read ports.
// ----------------------------------------------------------------------------
module scok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

@@ design/scok_front.sv @@
// ----------------------------------------------------------------------------
// scok_front: input word acceptance and two-entry queue
// Classifies each word, clamps the byte count and queues it for the back.
// ----------------------------------------------------------------------------
module scok_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [135:0]          s_tdata,
    input  logic                  s_tuser,
    output scok_pkg::queue_t      q_head,
    input  logic                  q_pop
);
    scok_pkg::item_t ent_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    scok_pkg::item_t in_item;
    logic            push;

    // classify incoming word
    always_comb begin
        in_item.action    = s_tuser;
        in_item.word_high = s_tdata[63:0];
        in_item.word_low  = s_tdata[127:64];
        in_item.byte_count = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
    end

    assign s_tready     = (cnt_reg != 2'd2);
    assign push         = s_tvalid && s_tready;
    assign q_head.valid = (cnt_reg != 2'd0);
    assign q_head.item  = ent_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, q_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end
endmodule

@@ design/scok_back.sv @@
// ----------------------------------------------------------------------------
// scok_back: key schedule and keystream engine
// Runs the schedule sequencer and the round sequencer on one permutation RAM.
// ----------------------------------------------------------------------------
module scok_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [63:0]           cfg_data,
    input  scok_pkg::queue_t      q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [135:0]          m_tdata
);
    localparam logic [3:0] ST_FILL  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_WORDS = 4'd2;
    localparam logic [3:0] ST_SRD   = 4'd3;
    localparam logic [3:0] ST_SW1   = 4'd4;
    localparam logic [3:0] ST_SW2   = 4'd5;
    localparam logic [3:0] ST_PRD   = 4'd6;
    localparam logic [3:0] ST_PEND  = 4'd7;
    localparam logic [3:0] ST_ADD   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam logic [9:0] PASS_LAST  = 10'(scok_pkg::SCHED_PASSES - 1);
    localparam logic [1:0] ROUND_LAST = 2'(scok_pkg::ROUNDS - 1);

    logic [3:0]        state_reg;
    logic              sched_pend_reg;
    logic [63:0]       key_high_reg, key_low_reg;
    logic [15:0][31:0] rw_reg;
    logic [31:0]       add_reg, acc_reg;
    logic [3:0][31:0]  chain_reg;
    logic [15:0][7:0]  kb_reg;
    logic [4:0]        idx_reg;
    logic [4:0]        step_reg;
    logic [9:0]        pass_reg;
    logic [1:0]        perm_reg;
    logic [6:0]        fill_reg;
    logic [1:0]        round_reg, grp_reg;
    logic [4:0]        ccnt_reg;
    logic              pend_reg;
    logic [31:0]       w_reg;
    logic [4:0]        swp_a_reg;
    scok_pkg::item_t   cur_reg;
    logic              ovalid_reg;
    logic [135:0]      odata_reg;

    logic                             ram_we;
    logic [scok_pkg::PERM_AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [scok_pkg::PERM_W-1:0]      ram_wdata, ram_rdata_a, ram_rdata_b;

    logic [31:0] sum4;
    logic [4:0]  idx_next;
    logic [31:0] w_swp, w_fin;
    logic [3:0][31:0] chain_add;
    logic [31:0] ks_hi_a, ks_hi_b, ks_lo_a, ks_lo_b;
    logic [63:0] out_hi, out_lo;

    assign cfg_ready = 1'b1;
    assign q_pop     = (state_reg == ST_IDLE) && q_head.valid;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = odata_reg;

    // permutation table
    scok_ram #(.WIDTH(scok_pkg::PERM_W), .DEPTH(scok_pkg::PERM_DEPTH)) u_perm (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // running sum, schedule index and swap chain datapath
    assign sum4     = rw_reg[0] + rw_reg[1] + rw_reg[2] + rw_reg[3];
    assign idx_next = idx_reg + kb_reg[0][4:0];
    assign w_swp    = pend_reg ? scok_pkg::exch_bits(w_reg, ram_rdata_a, ram_rdata_b) : w_reg;
    assign w_fin    = w_swp ^ chain_reg[grp_reg - 2'd1] ^ rw_reg[{round_reg, grp_reg}];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            chain_add[i] = chain_reg[i] + add_reg;
        end
    end

    // output masking, bytes past the count cleared
    assign ks_hi_a = chain_reg[0];
    assign ks_hi_b = chain_reg[1];
    assign ks_lo_a = chain_reg[2];
    assign ks_lo_b = chain_reg[3];
    always_comb begin
        out_hi = cur_reg.word_high ^ {ks_hi_a, ks_hi_b};
        out_lo = cur_reg.word_low ^ {ks_lo_a, ks_lo_b};
        for (int j = 0; j < 8; j++) begin
            if (5'(j) >= cur_reg.byte_count) begin
                out_hi[63 - 8*j -: 8] = 8'h00;
            end
            if (5'(j + 8) >= cur_reg.byte_count) begin
                out_lo[63 - 8*j -: 8] = 8'h00;
            end
        end
    end

    // ram port control
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = {perm_reg, pass_reg[4:0]};
        ram_wdata   = ram_rdata_b;
        ram_raddr_a = {grp_reg, ccnt_reg};
        ram_raddr_b = {grp_reg, ccnt_reg + 5'd1};
        case (state_reg)
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                ram_wdata = fill_reg[4:0];
            end
            ST_SRD: begin
                ram_raddr_a = {perm_reg, pass_reg[4:0]};
                ram_raddr_b = {perm_reg, idx_next};
            end
            ST_SW1: begin
                ram_we = 1'b1;
            end
            ST_SW2: begin
                ram_we    = 1'b1;
                ram_waddr = {perm_reg, idx_reg};
                ram_wdata = swp_a_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                scok_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                scok_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:                key_low_reg  <= key_low_reg;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cur_reg   <= q_head.item;
                round_reg <= 2'd0;
                grp_reg   <= 2'd0;
                ccnt_reg  <= 5'd0;
                pend_reg  <= 1'b0;
                w_reg     <= chain_reg[0];
                step_reg  <= 5'd0;
                pass_reg  <= 10'd0;
                perm_reg  <= 2'd0;
                idx_reg   <= 5'd0;
                for (int i = 0; i < 8; i++) begin
                    kb_reg[i]     <= key_high_reg[63 - 8*i -: 8];
                    kb_reg[8 + i] <= key_low_reg[63 - 8*i -: 8];
                end
            end
            ST_SRD: begin
                idx_reg <= idx_next;
                kb_reg  <= {kb_reg[0] + kb_reg[1], kb_reg[15:1]};
            end
            ST_SW1: begin
                swp_a_reg <= ram_rdata_a;
            end
            ST_SW2: begin
                pass_reg <= (pass_reg == PASS_LAST) ? 10'd0 : pass_reg + 10'd1;
                if (pass_reg == PASS_LAST) begin
                    perm_reg <= perm_reg + 2'd1;
                end
            end
            ST_WORDS: begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'd0) begin
                    acc_reg <= sum4 + 32'h0000_0001;
                end else begin
                    acc_reg <= sum4 + acc_reg;
                end
            end
            ST_PRD: begin
                w_reg    <= w_swp;
                pend_reg <= 1'b1;
                ccnt_reg <= ccnt_reg + 5'd1;
            end
            ST_PEND: begin
                pend_reg <= 1'b0;
                ccnt_reg <= 5'd0;
                grp_reg  <= grp_reg + 2'd1;
                w_reg    <= chain_reg[grp_reg + 2'd1];
            end
            ST_ADD: begin
                round_reg <= round_reg + 2'd1;
                w_reg     <= chain_add[0];
            end
            default: begin
                pend_reg <= pend_reg;
            end
        endcase
    end

    // state words: round words, additive word, chain block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rw_reg    <= '0;
            add_reg   <= '0;
            chain_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_head.valid && q_head.item.action == scok_pkg::ACT_SCHED) begin
                        chain_reg <= {q_head.item.word_low[31:0], q_head.item.word_low[63:32],
                                      q_head.item.word_high[31:0],
                                      q_head.item.word_high[63:32]};
                        rw_reg[0] <= key_high_reg[63:32];
                        rw_reg[1] <= key_high_reg[31:0];
                        rw_reg[2] <= key_low_reg[63:32];
                        rw_reg[3] <= key_low_reg[31:0];
                    end
                end
                ST_WORDS: begin
                    if (step_reg == 5'd17) begin
                        add_reg <= sum4 + acc_reg;
                    end else if (step_reg != 5'd0) begin
                        rw_reg[step_reg[3:0] - 4'd1] <= sum4 + acc_reg;
                    end
                end
                ST_PEND: begin
                    chain_reg[grp_reg] <= w_fin;
                end
                ST_ADD: begin
                    chain_reg <= chain_add;
                end
                default: begin
                    add_reg <= add_reg;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!ovalid_reg || m_tready)) begin
            odata_reg <= {3'b000, cur_reg.byte_count, out_lo, out_hi};
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            sched_pend_reg <= 1'b0;
            fill_reg       <= 7'd0;
            ovalid_reg     <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && (!ovalid_reg || m_tready)) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_FILL: begin
                    fill_reg <= fill_reg + 7'd1;
                    if (fill_reg == 7'(scok_pkg::PERM_DEPTH - 1)) begin
                        state_reg      <= sched_pend_reg ? ST_SRD : ST_IDLE;
                        sched_pend_reg <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (q_head.valid) begin
                        state_reg <= (q_head.item.action == scok_pkg::ACT_SCHED) ?
                                     ST_WORDS : ST_PRD;
                    end
                end
                ST_WORDS: begin
                    if (step_reg == 5'd17) begin
                        state_reg      <= ST_FILL;
                        sched_pend_reg <= 1'b1;
                    end
                end
                ST_SRD:  state_reg <= ST_SW1;
                ST_SW1:  state_reg <= ST_SW2;
                ST_SW2: begin
                    if (pass_reg == PASS_LAST && perm_reg == 2'd3) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_SRD;
                    end
                end
                ST_PRD: begin
                    if (ccnt_reg == 5'd30) begin
                        state_reg <= ST_PEND;
                    end
                end
                ST_PEND: begin
                    state_reg <= (grp_reg == 2'd3) ? ST_ADD : ST_PRD;
                end
                ST_ADD: begin
                    state_reg <= (round_reg == ROUND_LAST) ? ST_OUT : ST_PRD;
                end
                ST_OUT: begin
                    if (!ovalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // no word is taken while the table is swept or the engine is busy
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped outside idle");

    // a result appears only after the round sequencer finished
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    // the swap chain never issues past the last pair
    a_chain_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PRD |-> ccnt_reg <= 5'd30)
        else $error("swap chain counter overrun");

    // table writes only happen in sweep or swap states
    a_ram_we: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_FILL || state_reg == ST_SW1 || state_reg == ST_SW2))
        else $error("table written outside schedule");
endmodule

@@ design/swap_cipher_ofb_keystream.sv @@
// ----------------------------------------------------------------------------
// swap_cipher_ofb_keystream: swap-cipher keystream block, output feedback
// Top level joining the input queue and the schedule and round engine.
// ----------------------------------------------------------------------------
// Input words arrive on s_ (tuser = action): action 0 loads the IV from
// tdata and runs the key schedule from the two key registers, written on the
// cfg_ port (index 0 key high, 1 key low); the user must write them only
// while the block is idle; the block itself does not enforce it. Action 0
// gives no result. Action 1 advances the chain block and returns one word on
// m_: data XOR keystream, bytes past the count zeroed, count clamped to 16.
// A data word runs four rounds of four words, each word a 31-step swap chain
// driven by one dual-read permutation RAM, plus an add step a round. A
// schedule word derives the round words, sweeps the table to identity and
// makes 3072 table swaps, each a read and two writes. After reset the table
// is swept to identity; words queue in the front meanwhile. A two-word queue
// takes input while the engine works; a stalled receiver holds the result
// register and the engine waits before writing the next result.
// ----------------------------------------------------------------------------
module swap_cipher_ofb_keystream (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // word_high, word_low, byte_count, zero pad
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // out_high, out_low, out_count, zero pad
);
    scok_pkg::queue_t q_head;
    logic             q_pop;

    // input side
    scok_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // engine side
    scok_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: regression bench for the swap-cipher keystream block
// Drives IV loads and data words through the stream port and key writes
// through the config port. A local copy of the schedule and round logic
// predicts each result, which is compared field by field as it leaves.
// ----------------------------------------------------------------------------
module tb_top;

    // result word as seen on m_tdata, out_high in the low bits
    typedef struct packed {
        logic [4:0]  out_count;
        logic [63:0] out_low;
        logic [63:0] out_high;
    } cipher_word_t;

    localparam int SCHED_WAIT  = 10000;
    localparam int CYCLE_LIMIT = 6000000;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = scok_pkg::REG_KEY_HIGH;
    logic [63:0]  cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata   = '0;
    logic         s_tuser   = scok_pkg::ACT_SCHED;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [135:0] m_tdata;

    swap_cipher_ofb_keystream uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // word_high, word_low, byte_count, zero pad
        .s_tuser   (s_tuser),   // action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // out_high, out_low, out_count, zero pad
    );

    // predictor state
    logic [63:0]  key_hi_shadow, key_lo_shadow;
    logic [31:0]  round_key [16];
    logic [31:0]  add_key;
    logic [4:0]   perm_tab [128];
    logic [31:0]  chain [4];
    logic [7:0]   work_key [16];
    logic [4:0]   swap_idx;

    cipher_word_t expected_words [$];
    int           errors     = 0;
    longint       cycles     = 0;
    int           hold_left  = 0;
    int           stall_left = 0;
    bit           rx_busy_ok = 1'b1;
    bit           tx_gaps    = 1'b1;

    // clock
    always #6 aclk = ~aclk;

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls plus an occasional long forced hold
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (rx_busy_ok && $urandom_range(0, 99) < 6)
                stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                          : $urandom_range(30, 400);
        end
    end

    // result checker
    always @(posedge aclk) begin
        cipher_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = cipher_word_t'(m_tdata[132:0]);
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $time, got);
            end else begin
                want = expected_words.pop_front();
                if (got.out_high !== want.out_high) begin
                    errors++;
                    $display("%0t: out_high exp %h got %h", $time, want.out_high,
                             got.out_high);
                end
                if (got.out_low !== want.out_low) begin
                    errors++;
                    $display("%0t: out_low exp %h got %h", $time, want.out_low,
                             got.out_low);
                end
                if (got.out_count !== want.out_count) begin
                    errors++;
                    $display("%0t: out_count exp %0d got %0d", $time, want.out_count,
                             got.out_count);
                end
                if (m_tdata[135:133] !== 3'b000) begin
                    errors++;
                    $display("%0t: pad exp 0 got %b", $time, m_tdata[135:133]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic model_reset();
        key_hi_shadow = '0;
        key_lo_shadow = '0;
        add_key       = '0;
        swap_idx      = '0;
        for (int i = 0; i < 16; i++) begin
            round_key[i] = '0;
            work_key[i]  = '0;
        end
        for (int i = 0; i < 128; i++) perm_tab[i] = 5'(i);
        for (int i = 0; i < 4; i++) chain[i] = '0;
    endtask

    function automatic logic [31:0] key_word_sum();
        return round_key[0] + round_key[1] + round_key[2] + round_key[3];
    endfunction

    task automatic build_schedule();
        logic [31:0] acc;
        logic [4:0]  tmp;
        int          a, s;
        for (int i = 0; i < 8; i++) begin
            work_key[i]     = key_hi_shadow[63 - 8*i -: 8];
            work_key[8 + i] = key_lo_shadow[63 - 8*i -: 8];
        end
        for (int i = 0; i < 4; i++)
            round_key[i] = {work_key[4*i], work_key[4*i+1], work_key[4*i+2],
                            work_key[4*i+3]};
        // running sums see round words as they are overwritten
        acc = key_word_sum() + 32'd1;
        for (int i = 0; i < 16; i++) begin
            acc = key_word_sum() + acc;
            round_key[i] = acc;
        end
        add_key = key_word_sum() + acc;
        for (int i = 0; i < 128; i++) perm_tab[i] = 5'(i);
        // key driven swaps, index carried across the four tables
        swap_idx = '0;
        for (int l = 0; l < 4; l++) begin
            for (int i = 0; i < scok_pkg::SCHED_PASSES; i++) begin
                a = i % 16;
                s = i % 32;
                swap_idx = swap_idx + work_key[a][4:0];
                work_key[a] = work_key[a] + work_key[(i + 1) % 16];
                tmp = perm_tab[l*32 + s];
                perm_tab[l*32 + s] = perm_tab[l*32 + swap_idx];
                perm_tab[l*32 + swap_idx] = tmp;
            end
        end
    endtask

    function automatic logic [31:0] swap_chain(logic [31:0] w, int l);
        logic [4:0] p, q;
        for (int i = 0; i < 31; i++) begin
            p = perm_tab[l*32 + i];
            q = perm_tab[l*32 + i + 1];
            if (w[p] != w[q]) begin
                w[p] = ~w[p];
                w[q] = ~w[q];
            end
        end
        return w;
    endfunction

    function automatic logic [63:0] keep_bytes(int n);
        logic [63:0] m = '0;
        for (int b = 0; b < 8; b++)
            if (b < n) m[63 - 8*b -: 8] = 8'hFF;
        return m;
    endfunction

    task automatic predict_word(logic act, logic [63:0] hi, logic [63:0] lo,
                                logic [4:0] cnt);
        cipher_word_t res;
        int           n;
        if (act == scok_pkg::ACT_SCHED) begin
            chain[0] = hi[63:32];
            chain[1] = hi[31:0];
            chain[2] = lo[63:32];
            chain[3] = lo[31:0];
            build_schedule();
        end else begin
            for (int r = 0; r < scok_pkg::ROUNDS; r++) begin
                for (int g = 0; g < 4; g++)
                    chain[g] = swap_chain(chain[g], g) ^ chain[(g + 3) % 4]
                               ^ round_key[r*4 + g];
                for (int g = 0; g < 4; g++) chain[g] = chain[g] + add_key;
            end
            n = (cnt > 16) ? 16 : cnt;
            res.out_high  = (hi ^ {chain[0], chain[1]}) & keep_bytes(n);
            res.out_low   = (lo ^ {chain[2], chain[3]}) & keep_bytes(n - 8);
            res.out_count = 5'(n);
            expected_words.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_word(logic act, logic [63:0] hi, logic [63:0] lo,
                             logic [4:0] cnt);
        int gap;
        gap = 0;
        if (tx_gaps && $urandom_range(0, 9) >= 6)
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                              : $urandom_range(20, 300);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, cnt, lo, hi};
        do @(posedge aclk); while (!s_tready);
        predict_word(act, hi, lo, cnt);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        // a schedule word leaves no result, so allow it to finish
        repeat (SCHED_WAIT) @(posedge aclk);
    endtask

    task automatic write_key(logic idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == scok_pkg::REG_KEY_HIGH) key_hi_shadow = val;
        else key_lo_shadow = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [4:0] rand_count();
        case ($urandom_range(0, 9))
            0, 1:    return 5'($urandom_range(0, 31));
            2:       return 5'($urandom_range(0, 16));
            default: return 5'd16;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        // data before any schedule runs on the reset tables
        send_word(scok_pkg::ACT_DATA, '1, '1, 5'd16);
        send_word(scok_pkg::ACT_DATA, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                  5'd0);
        send_word(scok_pkg::ACT_DATA, '0, '0, 5'd16);
        quiesce();
    endtask

    task automatic test_counts();
        logic [4:0] cnts [12] = '{5'd0, 5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16,
                                  5'd17, 5'd24, 5'd31, 5'd2, 5'd30};
        write_key(scok_pkg::REG_KEY_HIGH, 64'h0011_2233_4455_6677);
        write_key(scok_pkg::REG_KEY_LOW, 64'h8899_AABB_CCDD_EEFF);
        send_word(scok_pkg::ACT_SCHED, '1, '1, 5'd31);
        foreach (cnts[i]) send_word(scok_pkg::ACT_DATA, '1, '1, cnts[i]);
        send_word(scok_pkg::ACT_SCHED, '0, '0, 5'd0);
        send_word(scok_pkg::ACT_DATA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  5'd16);
        send_word(scok_pkg::ACT_DATA, '0, '0, 5'd16);
        quiesce();
    endtask

    task automatic test_random_phase(logic [63:0] khi, logic [63:0] klo, int items);
        write_key(scok_pkg::REG_KEY_HIGH, khi);
        write_key(scok_pkg::REG_KEY_LOW, klo);
        send_word(scok_pkg::ACT_SCHED, rand64(), rand64(), 5'($urandom_range(0, 31)));
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 99) < 2)
                send_word(scok_pkg::ACT_SCHED, rand64(), rand64(),
                          5'($urandom_range(0, 31)));
            else
                send_word(scok_pkg::ACT_DATA, rand64(), rand64(), rand_count());
        end
        quiesce();
    endtask

    task automatic test_backpressure();
        // long receiver hold while the sender keeps offering
        hold_left <= 4000;
        for (int i = 0; i < 8; i++)
            send_word(scok_pkg::ACT_DATA, rand64(), rand64(), 5'd16);
        quiesce();
    endtask

    task automatic test_no_idle();
        tx_gaps    = 1'b0;
        rx_busy_ok = 1'b0;
        for (int i = 0; i < 40; i++)
            send_word(scok_pkg::ACT_DATA, rand64(), rand64(), rand_count());
        send_word(scok_pkg::ACT_SCHED, rand64(), rand64(), 5'd0);
        for (int i = 0; i < 20; i++)
            send_word(scok_pkg::ACT_DATA, rand64(), rand64(), rand_count());
        quiesce();
        tx_gaps    = 1'b1;
        rx_busy_ok = 1'b1;
    endtask

    initial begin
        model_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_counts();
        test_random_phase('0, '0, 250);
        test_random_phase('1, '1, 250);
        test_backpressure();
        test_random_phase(rand64(), rand64(), 250);
        test_no_idle();
        test_random_phase(rand64(), rand64(), 300);

        repeat (600) @(posedge aclk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/scok_pkg.sv
design/scok_ram.sv
design/scok_front.sv
design/scok_back.sv
design/swap_cipher_ofb_keystream.sv
tb/tb_top.sv
